// File: rtl/core/ragged_tensor_index_walker_macros.svh
// Assertion macros for the ragged tensor index walker.
`ifndef RAGGED_TENSOR_INDEX_WALKER_MACROS_SVH
`define RAGGED_TENSOR_INDEX_WALKER_MACROS_SVH
`ifndef SYNTH
`define RTIW_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define RTIW_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RTIW_ASSERT_IMP(label, clk, rst_n, a, c)
`define RTIW_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/rtiw_pkg.sv
// Shared types and constants for the ragged tensor index walker.
`timescale 1ns / 1ps
`default_nettype none
package rtiw_pkg;
  localparam int DefMaxBatch  = 16;
  localparam int DefMaxExtent = 4096;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_FIRST  = 3'd2,
    CMD_LAST   = 3'd3,
    CMD_INC    = 3'd4,
    CMD_DEC    = 3'd5,
    CMD_ADD    = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_t;

  localparam logic [1:0] DIM_BATCH = 2'd0;
  localparam logic [1:0] DIM_ROW   = 2'd1;
  localparam logic [1:0] DIM_COL   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_EXEC,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture input item
    logic limit;   // compute and register dimension limits
    logic exec;    // execute command
    logic mul;     // register offset products
    logic sum;     // register linear offset
  } ctrl_t;
endpackage
`default_nettype wire

// File: rtl/core/ragged_tensor_index_walker.sv
// Top level of the ragged tensor index walker.
`timescale 1ns / 1ps
`default_nettype none
// Walks a batch/row/column position over a ragged tensor held in a dense
// buffer, with a table of per-batch sizes. One command item gives one result
// item. After a command is accepted the controller passes a limit lookup, the
// command step, the offset products and the offset sum, and then offers the
// result. The input is not ready again until the result has been taken and
// the controller is back in idle.
module ragged_tensor_index_walker #(
  parameter int MAX_BATCH  = rtiw_pkg::DefMaxBatch,
  parameter int MAX_EXTENT = rtiw_pkg::DefMaxExtent
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[2:0], entry_height[15:3], entry_width[28:16], batch_sel[32:29],
  // dim_sel[34:33], step_offset[48:35]
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // batch_index[15:0], row_index[31:16], col_index[47:32], linear_offset[88:48]
  output logic [95:0]      out_tdata,
  // ok
  output logic             out_tuser
);
  rtiw_pkg::ctrl_t ctrl;
  logic signed [15:0] bi, ri, ci;
  logic signed [40:0] lo;
  logic okv;

  rtiw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .ctrl(ctrl)
  );

  rtiw_datapath #(.MAX_BATCH(MAX_BATCH), .MAX_EXTENT(MAX_EXTENT)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .cmd(in_tdata[2:0]), .entry_height(in_tdata[15:3]),
    .entry_width(in_tdata[28:16]), .batch_sel(in_tdata[32:29]),
    .dim_sel(in_tdata[34:33]), .step_offset(in_tdata[48:35]),
    .batch_index(bi), .row_index(ri), .col_index(ci),
    .linear_offset(lo), .ok(okv)
  );

  assign out_tdata = {7'd0, lo, ci, ri, bi};
  assign out_tuser = okv;
endmodule
`default_nettype wire

// File: rtl/core/rtiw_datapath.sv
// Datapath: size table, position registers, limits and offset arithmetic.
`timescale 1ns / 1ps
`default_nettype none
`include "ragged_tensor_index_walker_macros.svh"
module rtiw_datapath #(
  parameter int MAX_BATCH  = rtiw_pkg::DefMaxBatch,
  parameter int MAX_EXTENT = rtiw_pkg::DefMaxExtent
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rtiw_pkg::ctrl_t    ctrl,
  input  wire logic [2:0]         cmd,
  input  wire logic [12:0]        entry_height,
  input  wire logic [12:0]        entry_width,
  input  wire logic [3:0]         batch_sel,
  input  wire logic [1:0]         dim_sel,
  input  wire logic signed [13:0] step_offset,
  output logic signed [15:0]      batch_index,
  output logic signed [15:0]      row_index,
  output logic signed [15:0]      col_index,
  output logic signed [40:0]      linear_offset,
  output logic                    ok
);
  localparam int CW = $clog2(MAX_BATCH + 1);
  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam logic [12:0] EXT = 13'(MAX_EXTENT > 8191 ? 8191 : MAX_EXTENT);

  logic [12:0] htab_r [MAX_BATCH];
  logic [12:0] wtab_r [MAX_BATCH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [12:0] mh_r, mh_nxt, mw_r, mw_nxt;
  logic [25:0] ps_r, ps_nxt;
  logic signed [15:0] pb_r, pr_r, pc_r, pb_nxt, pr_nxt, pc_nxt;
  logic ok_r, ok_nxt;
  logic [2:0] cmd_r;
  logic [12:0] eh_r, ew_r;
  logic [3:0] bs_r;
  logic [1:0] ds_r;
  logic signed [13:0] so_r;
  logic signed [16:0] lb_r, lr_r, lc_r, ln_r, lnc_r;
  logic signed [42:0] p0_r, p1_r;
  logic signed [40:0] off_r;

  // Row and column limits of a batch index.
  function automatic logic signed [16:0] lim_of(input logic signed [15:0] b,
      input logic rowsel, input logic [CW-1:0] cnt,
      input logic [12:0] mh, input logic [12:0] mw,
      input logic [12:0] ht, input logic [12:0] wt);
    logic inside_tab;
    inside_tab = (b >= 0) && ($unsigned(17'(b)) < 17'(cnt));
    if (!inside_tab) lim_of = rowsel ? $signed({4'd0, mh}) - 17'sd1
                                     : $signed({4'd0, mw}) - 17'sd1;
    else lim_of = rowsel ? $signed({4'd0, ht}) - 17'sd1
                         : $signed({4'd0, wt}) - 17'sd1;
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [17:0] v);
    if (v > 18'sd32767) sat = 16'sh7fff;
    else if (v < -18'sd32768) sat = 16'sh8000;
    else sat = v[15:0];
  endfunction

  logic [AW-1:0] ai_cur, ai_sel, ai_dec;
  logic signed [15:0] bdec, bsel16;
  assign bdec   = pb_r - 16'sd1;
  assign bsel16 = $signed({12'd0, bs_r});
  assign ai_cur = AW'($unsigned(pb_r));
  assign ai_sel = AW'(bs_r);
  assign ai_dec = AW'($unsigned(bdec));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= cmd; eh_r <= entry_height; ew_r <= entry_width;
      bs_r <= batch_sel; ds_r <= dim_sel; so_r <= step_offset;
    end
    if (ctrl.limit) begin
      lb_r  <= $signed({{(17-CW){1'b0}}, cnt_r}) - 17'sd1;
      lr_r  <= lim_of(pb_r, 1'b1, cnt_r, mh_r, mw_r, htab_r[ai_cur], wtab_r[ai_cur]);
      lc_r  <= lim_of(pb_r, 1'b0, cnt_r, mh_r, mw_r, htab_r[ai_cur], wtab_r[ai_cur]);
      // Limits of the previous batch for a borrow, or of batch_sel for last.
      if (cmd_r == rtiw_pkg::CMD_LAST) begin
        ln_r  <= lim_of(bsel16, 1'b1, cnt_r, mh_r, mw_r, htab_r[ai_sel], wtab_r[ai_sel]);
        lnc_r <= lim_of(bsel16, 1'b0, cnt_r, mh_r, mw_r, htab_r[ai_sel], wtab_r[ai_sel]);
      end else begin
        ln_r  <= lim_of(bdec, 1'b1, cnt_r, mh_r, mw_r, htab_r[ai_dec], wtab_r[ai_dec]);
        lnc_r <= lim_of(bdec, 1'b0, cnt_r, mh_r, mw_r, htab_r[ai_dec], wtab_r[ai_dec]);
      end
    end
    if (ctrl.exec && cmd_r == rtiw_pkg::CMD_APPEND && 32'(cnt_r) < MAX_BATCH) begin
      htab_r[AW'(cnt_r)] <= (eh_r > EXT) ? EXT : eh_r;
      wtab_r[AW'(cnt_r)] <= (ew_r > EXT) ? EXT : ew_r;
    end
    if (ctrl.mul) begin
      p0_r <= 43'(pb_r * $signed({1'b0, ps_r}));
      p1_r <= 43'(pr_r * $signed({1'b0, mw_r}));
    end
    if (ctrl.sum) off_r <= 41'(p0_r + p1_r + 43'(pc_r));
  end

  // Validity with the limits that follow a new position.
  function automatic logic valid3(input logic signed [15:0] b,
      input logic signed [15:0] r, input logic signed [15:0] c,
      input logic signed [16:0] lb, input logic signed [16:0] lr,
      input logic signed [16:0] lc);
    valid3 = (b >= 0) && (r >= 0) && (c >= 0) && (17'(b) <= lb)
             && (17'(r) <= lr) && (17'(c) <= lc);
  endfunction

  logic signed [17:0] addv;
  logic signed [15:0] addr_sel;
  logic [12:0] ehs, ews;

  always_comb begin
    cnt_nxt = cnt_r; mh_nxt = mh_r; mw_nxt = mw_r; ps_nxt = ps_r;
    pb_nxt = pb_r; pr_nxt = pr_r; pc_nxt = pc_r; ok_nxt = 1'b0;
    ehs = (eh_r > EXT) ? EXT : eh_r;
    ews = (ew_r > EXT) ? EXT : ew_r;
    addr_sel = (ds_r == rtiw_pkg::DIM_BATCH) ? pb_r :
               (ds_r == rtiw_pkg::DIM_ROW) ? pr_r : pc_r;
    addv = 18'(addr_sel) + 18'(so_r);
    unique case (rtiw_pkg::cmd_t'(cmd_r))
      rtiw_pkg::CMD_CLEAR: begin
        cnt_nxt = '0; mh_nxt = '0; mw_nxt = '0; ps_nxt = '0;
        pb_nxt = '0; pr_nxt = '0; pc_nxt = '0; ok_nxt = 1'b1;
      end
      rtiw_pkg::CMD_APPEND: begin
        if (32'(cnt_r) < MAX_BATCH) begin
          cnt_nxt = cnt_r + 1'b1;
          if (ehs > mh_r) mh_nxt = ehs;
          if (ews > mw_r) mw_nxt = ews;
          ps_nxt = mh_nxt * mw_nxt;
          ok_nxt = 1'b1;
        end
      end
      rtiw_pkg::CMD_FIRST: begin
        pb_nxt = '0; pr_nxt = '0; pc_nxt = '0;
        // Batch 0 is valid when the table is not empty and its first entry has nonzero height and width.
        ok_nxt = (cnt_r != '0) && (htab_r[0] != '0) && (wtab_r[0] != '0);
      end
      rtiw_pkg::CMD_LAST: begin
        pb_nxt = bsel16; pr_nxt = ln_r[15:0]; pc_nxt = lnc_r[15:0];
        ok_nxt = valid3(bsel16, ln_r[15:0], lnc_r[15:0], lb_r, ln_r, lnc_r);
      end
      rtiw_pkg::CMD_INC: begin
        if (17'(pc_r) != lc_r) begin
          pc_nxt = sat(18'(pc_r) + 18'sd1); ok_nxt = 1'b1;
        end else if (17'(pr_r) != lr_r) begin
          pc_nxt = '0; pr_nxt = sat(18'(pr_r) + 18'sd1); ok_nxt = 1'b1;
        end else if (17'(pb_r) != lb_r) begin
          pc_nxt = '0; pr_nxt = '0; pb_nxt = sat(18'(pb_r) + 18'sd1); ok_nxt = 1'b1;
        end else begin
          pc_nxt = '0; pr_nxt = '0; pb_nxt = '0;
        end
      end
      rtiw_pkg::CMD_DEC: begin
        if (pc_r > 0) begin
          pc_nxt = pc_r - 16'sd1; ok_nxt = 1'b1;
        end else if (pr_r > 0) begin
          pc_nxt = lc_r[15:0]; pr_nxt = pr_r - 16'sd1; ok_nxt = 1'b1;
        end else if (pb_r > 0) begin
          pb_nxt = bdec; pr_nxt = ln_r[15:0]; pc_nxt = lnc_r[15:0]; ok_nxt = 1'b1;
        end else begin
          pc_nxt = lc_r[15:0]; pr_nxt = lr_r[15:0]; pb_nxt = lb_r[15:0];
        end
      end
      rtiw_pkg::CMD_ADD: begin
        if (ds_r == rtiw_pkg::DIM_BATCH) begin
          pb_nxt = sat(addv);
          // Row and column limits follow the new batch; checked in the offset-sum step (ST_SUM).
          ok_nxt = 1'b0;
        end else if (ds_r == rtiw_pkg::DIM_ROW) begin
          pr_nxt = sat(addv);
          ok_nxt = valid3(pb_r, pr_nxt, pc_r, lb_r, lr_r, lc_r);
        end else if (ds_r == rtiw_pkg::DIM_COL) begin
          pc_nxt = sat(addv);
          ok_nxt = valid3(pb_r, pr_r, pc_nxt, lb_r, lr_r, lc_r);
        end
      end
      default: ;
    endcase
  end

  // After a batch offset the limits are taken again from the new batch (ST_SUM).
  logic fix_ok;
  assign fix_ok = (cmd_r == rtiw_pkg::CMD_ADD) && (ds_r == rtiw_pkg::DIM_BATCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; mh_r <= '0; mw_r <= '0; ps_r <= '0;
      pb_r <= '0; pr_r <= '0; pc_r <= '0; ok_r <= 1'b0;
    end else if (ctrl.exec) begin
      cnt_r <= cnt_nxt; mh_r <= mh_nxt; mw_r <= mw_nxt; ps_r <= ps_nxt;
      pb_r <= pb_nxt; pr_r <= pr_nxt; pc_r <= pc_nxt; ok_r <= ok_nxt;
    end else if (ctrl.sum && fix_ok) begin
      ok_r <= valid3(pb_r, pr_r, pc_r, lb_r, lim_of(pb_r, 1'b1, cnt_r, mh_r, mw_r,
              htab_r[ai_cur], wtab_r[ai_cur]), lim_of(pb_r, 1'b0, cnt_r, mh_r, mw_r,
              htab_r[ai_cur], wtab_r[ai_cur]));
    end
  end

  assign batch_index   = pb_r;
  assign row_index     = pr_r;
  assign col_index     = pc_r;
  assign linear_offset = off_r;
  assign ok            = ok_r;

  `RTIW_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, 32'(cnt_r) <= MAX_BATCH)
  `RTIW_ASSERT_NXT(a_clear, clk, rst_n, ctrl.exec && cmd_r == rtiw_pkg::CMD_CLEAR,
                   cnt_r == '0 && pb_r == '0)
  `RTIW_ASSERT_IMP(a_ext, clk, rst_n, 1'b1, mh_r <= EXT && mw_r <= EXT)
endmodule
`default_nettype wire

// File: rtl/core/rtiw_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "ragged_tensor_index_walker_macros.svh"
module rtiw_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output rtiw_pkg::ctrl_t   ctrl
);
  rtiw_pkg::state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rtiw_pkg::ST_IDLE:  if (in_tvalid) st_nxt = rtiw_pkg::ST_LIMIT;
      rtiw_pkg::ST_LIMIT: st_nxt = rtiw_pkg::ST_EXEC;
      rtiw_pkg::ST_EXEC:  st_nxt = rtiw_pkg::ST_MUL;
      rtiw_pkg::ST_MUL:   st_nxt = rtiw_pkg::ST_SUM;
      rtiw_pkg::ST_SUM:   st_nxt = rtiw_pkg::ST_OUT;
      rtiw_pkg::ST_OUT:   if (out_tready) st_nxt = rtiw_pkg::ST_IDLE;
      default:            st_nxt = rtiw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (st_r)
      rtiw_pkg::ST_IDLE:  begin in_tready = 1'b1; ctrl.load = in_tvalid; end
      rtiw_pkg::ST_LIMIT: ctrl.limit = 1'b1;
      rtiw_pkg::ST_EXEC:  ctrl.exec = 1'b1;
      rtiw_pkg::ST_MUL:   ctrl.mul = 1'b1;
      rtiw_pkg::ST_SUM:   begin ctrl.sum = 1'b1; ctrl.limit = 1'b1; end
      rtiw_pkg::ST_OUT:   out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= rtiw_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  `RTIW_ASSERT_IMP(a_excl, clk, rst_n, 1'b1, !(in_tready && out_tvalid))
  `RTIW_ASSERT_NXT(a_load, clk, rst_n, in_tvalid && in_tready, st_r == rtiw_pkg::ST_LIMIT)
  `RTIW_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule
`default_nettype wire

// File: test/tb_ragged_tensor_index_walker.sv
// Testbench for the ragged tensor index walker: random and directed commands.
`timescale 1ns / 1ps
`default_nettype none
module tb_ragged_tensor_index_walker;

  localparam int NumBatch  = rtiw_pkg::DefMaxBatch;
  localparam int MaxExtent = rtiw_pkg::DefMaxExtent;

  typedef struct packed {
    logic signed [15:0] b;
    logic signed [15:0] r;
    logic signed [15:0] c;
    logic signed [40:0] ofs;
    logic               ok;
  } walk_res_t;

  class walk_scoreboard;
    int unsigned heights[NumBatch];
    int unsigned widths[NumBatch];
    int unsigned n_entries;
    int unsigned max_h;
    int unsigned max_w;
    longint stride;
    int pos[3];
    walk_res_t pending[$];
    int errors;
    int n_checked;

    function new();
      n_entries = 0; max_h = 0; max_w = 0; stride = 0;
      pos[0] = 0; pos[1] = 0; pos[2] = 0;
      errors = 0; n_checked = 0;
    endfunction

    function int sat(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int limit_of(int d);
      int bi;
      bi = pos[0];
      if (d == 0) return int'(n_entries) - 1;
      if (bi < 0 || bi >= int'(n_entries)) return d == 1 ? int'(max_h) - 1 : int'(max_w) - 1;
      return d == 1 ? int'(heights[bi]) - 1 : int'(widths[bi]) - 1;
    endfunction

    function bit pos_valid();
      for (int d = 0; d < 3; d++) if (pos[d] < 0) return 0;
      for (int d = 0; d < 3; d++) if (pos[d] > limit_of(d)) return 0;
      return 1;
    endfunction

    function void go_last(int bi);
      pos[0] = bi;
      pos[1] = limit_of(1);
      pos[2] = limit_of(2);
    endfunction

    function void note_command(logic [55:0] item);
      rtiw_pkg::cmd_t cmd;
      int unsigned eh, ew;
      int dsel, offs, d;
      bit ok, done;
      walk_res_t res;
      cmd = rtiw_pkg::cmd_t'(item[2:0]);
      eh = item[15:3];
      ew = item[28:16];
      dsel = item[34:33];
      offs = int'($signed(item[48:35]));
      ok = 0;
      case (cmd)
        rtiw_pkg::CMD_CLEAR: begin
          n_entries = 0; max_h = 0; max_w = 0; stride = 0;
          pos[0] = 0; pos[1] = 0; pos[2] = 0;
          ok = 1;
        end
        rtiw_pkg::CMD_APPEND: begin
          if (n_entries < NumBatch) begin
            if (eh > MaxExtent) eh = MaxExtent;
            if (ew > MaxExtent) ew = MaxExtent;
            heights[n_entries] = eh;
            widths[n_entries] = ew;
            n_entries++;
            if (eh > max_h) max_h = eh;
            if (ew > max_w) max_w = ew;
            stride = longint'(max_h) * longint'(max_w);
            ok = 1;
          end
        end
        rtiw_pkg::CMD_FIRST: begin
          pos[0] = 0; pos[1] = 0; pos[2] = 0;
          ok = pos_valid();
        end
        rtiw_pkg::CMD_LAST: begin
          go_last(int'(item[32:29]));
          ok = pos_valid();
        end
        rtiw_pkg::CMD_INC: begin
          done = 0;
          for (d = 2; d >= 0 && !done; d--) begin
            if (pos[d] != limit_of(d)) begin
              pos[d] = sat(longint'(pos[d]) + 1);
              done = 1;
            end else begin
              pos[d] = 0;
            end
          end
          ok = done;
        end
        rtiw_pkg::CMD_DEC: begin
          done = 0;
          for (d = 2; d >= 0 && !done; d--) begin
            if (pos[d] > 0) begin
              pos[d]--;
              if (d == 0) go_last(pos[0]);
              done = 1;
            end else begin
              pos[d] = limit_of(d);
            end
          end
          ok = done;
        end
        rtiw_pkg::CMD_ADD: begin
          if (dsel < 3) begin
            pos[dsel] = sat(longint'(pos[dsel]) + offs);
            ok = pos_valid();
          end
        end
        default: ok = 0;
      endcase
      res.b = pos[0][15:0];
      res.r = pos[1][15:0];
      res.c = pos[2][15:0];
      res.ofs = 41'(longint'(pos[0]) * stride + longint'(pos[1]) * longint'(max_w)
                    + longint'(pos[2]));
      res.ok = ok;
      pending = {pending, res};
    endfunction

    function void check_result(logic [95:0] data, logic flag);
      walk_res_t exp_res;
      if (pending.size() == 0) begin
        $error("result with nothing expected: data=%h ok=%b", data, flag);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      n_checked++;
      if (data[15:0] !== exp_res.b) begin
        $error("batch_index expected %0d actual %0d", exp_res.b, $signed(data[15:0]));
        errors++;
      end
      if (data[31:16] !== exp_res.r) begin
        $error("row_index expected %0d actual %0d", exp_res.r, $signed(data[31:16]));
        errors++;
      end
      if (data[47:32] !== exp_res.c) begin
        $error("col_index expected %0d actual %0d", exp_res.c, $signed(data[47:32]));
        errors++;
      end
      if (data[88:48] !== exp_res.ofs) begin
        $error("linear_offset expected %0d actual %0d", exp_res.ofs, $signed(data[88:48]));
        errors++;
      end
      if (flag !== exp_res.ok) begin
        $error("ok expected %0b actual %0b", exp_res.ok, flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tuser;

  walk_scoreboard sb;
  int  n_sent;
  int  cmd_hits[8];
  int  ok_hits;
  bit  stall_on;
  int  burst_left;

  ragged_tensor_index_walker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: stalls at random, with long stretches of full readiness.
  initial begin
    int phase;
    phase = 0;
    out_tready = 0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 400 < 100) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
      if (out_tuser) ok_hits++;
    end
  end

  task automatic send(rtiw_pkg::cmd_t cmd, int unsigned eh, int unsigned ew,
                      int unsigned bsel, int unsigned dsel, int offs);
    logic [55:0] item;
    logic [13:0] o14;
    int gap;
    o14 = offs[13:0];
    item = '0;
    item[2:0] = cmd;
    item[15:3] = eh[12:0];
    item[28:16] = ew[12:0];
    item[32:29] = bsel[3:0];
    item[34:33] = dsel[1:0];
    item[48:35] = o14;
    // Sender runs in bursts separated by random gaps.
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tdata <= item;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(item);
    cmd_hits[cmd]++;
    n_sent++;
    @(negedge clk);
  endtask

  task automatic rand_cmd();
    int sel;
    int offs;
    sel = $urandom_range(0, 99);
    offs = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 8192)) - 4096
                                     : int'($urandom_range(0, 8)) - 4;
    if (sel < 3) send(rtiw_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, offs);
    else if (sel < 8) send(rtiw_pkg::CMD_APPEND, $urandom_range(0, 8191),
                           $urandom_range(0, 8191), $urandom, $urandom, offs);
    else if (sel < 12) send(rtiw_pkg::CMD_FIRST, $urandom, $urandom, $urandom, $urandom, offs);
    else if (sel < 18) send(rtiw_pkg::CMD_LAST, $urandom, $urandom, $urandom_range(0, 15),
                            $urandom, offs);
    else if (sel < 55) send(rtiw_pkg::CMD_INC, $urandom, $urandom, $urandom, $urandom, offs);
    else if (sel < 85) send(rtiw_pkg::CMD_DEC, $urandom, $urandom, $urandom, $urandom, offs);
    else if (sel < 98) send(rtiw_pkg::CMD_ADD, $urandom, $urandom, $urandom,
                            $urandom_range(0, 3), offs);
    else send(rtiw_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom, offs);
  endtask

  initial begin
    int waited;
    int n_tab;
    sb = new();
    n_sent = 0;
    ok_hits = 0;
    burst_left = 0;
    foreach (cmd_hits[i]) cmd_hits[i] = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty table, extremes, full table, saturation, unknown codes.
    send(rtiw_pkg::CMD_INC, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_DEC, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_FIRST, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_LAST, 0, 0, 15, 0, 0);
    send(rtiw_pkg::CMD_APPEND, 8191, 8191, 0, 0, 0);
    send(rtiw_pkg::CMD_APPEND, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_APPEND, 2, 3, 0, 0, 0);
    send(rtiw_pkg::CMD_LAST, 0, 0, 2, 0, 0);
    send(rtiw_pkg::CMD_INC, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_DEC, 0, 0, 0, 0, 0);
    send(rtiw_pkg::CMD_ADD, 0, 0, 0, rtiw_pkg::DIM_COL, 4095);
    send(rtiw_pkg::CMD_ADD, 0, 0, 0, rtiw_pkg::DIM_ROW, -4096);
    for (int i = 0; i < 9; i++) send(rtiw_pkg::CMD_ADD, 0, 0, 0, rtiw_pkg::DIM_BATCH, 4095);
    send(rtiw_pkg::CMD_ADD, 0, 0, 0, 3, 7);
    for (int i = 0; i < 14; i++) send(rtiw_pkg::CMD_APPEND, 4096, 1, 0, 0, -1);
    send(rtiw_pkg::CMD_NOP, 8191, 8191, 15, 3, -1);
    send(rtiw_pkg::CMD_LAST, 0, 0, 15, 0, 0);
    send(rtiw_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);

    // Random: mostly small tables with a walk over them.
    while (n_sent < 1700) begin
      if ($urandom_range(0, 9) == 0) begin
        send(rtiw_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        n_tab = $urandom_range(1, 5);
        for (int i = 0; i < n_tab; i++)
          send(rtiw_pkg::CMD_APPEND, $urandom_range(0, 4), $urandom_range(0, 4), 0, 0, 0);
        send(rtiw_pkg::CMD_FIRST, 0, 0, 0, 0, 0);
      end
      rand_cmd();
    end
    in_tvalid <= 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    $display("Sent %0d commands (clear %0d, append %0d, inc %0d, dec %0d, add %0d).",
             n_sent, cmd_hits[rtiw_pkg::CMD_CLEAR], cmd_hits[rtiw_pkg::CMD_APPEND],
             cmd_hits[rtiw_pkg::CMD_INC], cmd_hits[rtiw_pkg::CMD_DEC],
             cmd_hits[rtiw_pkg::CMD_ADD]);
    $display("Checked %0d results, %0d with ok set, %0d mismatches.",
             sb.n_checked, ok_hits, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
